>>> hw/rtl/depth_to_space_address_generator_core_defines.svh
// Assertion macros shared by the address generator RTL.
// All macros sample on posedge clk and are disabled while arst_n is low.
`ifndef DEPTH_TO_SPACE_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define DEPTH_TO_SPACE_ADDRESS_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// cond holds at every edge
`define D2S_CHECK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("d2s check failed");

// ante implies cons in the same cycle
`define D2S_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("d2s implication failed");

// ante implies cons in the next cycle
`define D2S_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("d2s next-cycle check failed");

`else

`define D2S_CHECK(label, cond)
`define D2S_IMPLY(label, ante, cons)
`define D2S_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/d2s_pkg.sv
package d2s_pkg;

	// Build-time limits
	localparam int ADDR_BITS = 40;
	localparam int MAX_BLOCK = 16;
	localparam int MAX_DIM   = 2048;

	// Fixed field widths
	localparam int FIELD_W = 40;
	localparam int EB_W    = 4;
	localparam int BS_W    = 5;
	localparam int NB_W    = 9;
	localparam int CH_W    = 13;
	localparam int DIM_W   = 12;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 13;

	// Walk position widths
	localparam int N_W   = 8;
	localparam int C_W   = 12;
	localparam int PH_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int BLK_W = $clog2(MAX_DIM);

	// Address datapath widths
	localparam int PIDX_W = PH_W + BS_W + 1;
	localparam int BS2_W  = 2 * BS_W;
	localparam int ROW_W  = $clog2(MAX_DIM * MAX_BLOCK + 1);
	localparam int PIN_W  = 2 * DIM_W;
	localparam int ROFF_W = BLK_W + DIM_W + 1;
	localparam int NCH_W  = N_W + CH_W + 1;
	localparam int CIN_W  = C_W + BS2_W + PIDX_W;
	localparam int CCNT_W = CH_W + BS2_W;
	localparam int POUT_W = 2 * ROW_W;
	localparam int DROW_W = 2 * ROW_W + 1;
	localparam int NCIN_W = N_W + CCNT_W + 2;
	localparam int DST_W  = NCH_W + POUT_W + 1;
	localparam int SRC_W  = NCIN_W + PIN_W + 1;
	localparam int SRCE_W = SRC_W + EB_W;
	localparam int DSTE_W = DST_W + EB_W;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef logic [EB_W-1:0]   eb_t;
	typedef logic [BS_W-1:0]   bs_t;
	typedef logic [NB_W-1:0]   nb_t;
	typedef logic [CH_W-1:0]   ch_t;
	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [N_W-1:0]    n_t;
	typedef logic [C_W-1:0]    c_t;
	typedef logic [PH_W-1:0]   ph_t;
	typedef logic [BLK_W-1:0]  blk_t;
	typedef logic [PIDX_W-1:0] pidx_t;
	typedef logic [BS2_W-1:0]  bs2_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [PIN_W-1:0]  pin_t;
	typedef logic [ROFF_W-1:0] roff_t;
	typedef logic [NCH_W-1:0]  nch_t;
	typedef logic [CIN_W-1:0]  cin_t;
	typedef logic [CCNT_W-1:0] ccnt_t;
	typedef logic [POUT_W-1:0] pout_t;
	typedef logic [DROW_W-1:0] drow_t;
	typedef logic [NCIN_W-1:0] ncin_t;
	typedef logic [DST_W-1:0]  dst_t;
	typedef logic [SRC_W-1:0]  src_t;
	typedef logic [SRCE_W-1:0] srce_t;
	typedef logic [DSTE_W-1:0] dste_t;
	typedef logic [FIELD_W-1:0] addr_t;
	typedef logic [CFG_IW-1:0] cfg_idx_t;
	typedef logic [CFG_DW-1:0] cfg_data_t;
	typedef logic [Q_AW-1:0]   qptr_t;
	typedef logic [Q_AW:0]     qcnt_t;

	// Register indexes
	localparam cfg_idx_t REG_ELEMENT_BYTES = 3'd0;
	localparam cfg_idx_t REG_BLOCK_SIZE    = 3'd1;
	localparam cfg_idx_t REG_ORDER_MODE    = 3'd2;
	localparam cfg_idx_t REG_BATCH_COUNT   = 3'd3;
	localparam cfg_idx_t REG_OUT_CHANNELS  = 3'd4;
	localparam cfg_idx_t REG_IN_HEIGHT     = 3'd5;
	localparam cfg_idx_t REG_IN_WIDTH      = 3'd6;

	// Channel order
	localparam logic MODE_DCR = 1'b0;
	localparam logic MODE_CRD = 1'b1;

	// Address bits kept in the output fields
	localparam addr_t ADDR_MASK = (ADDR_BITS >= FIELD_W) ? '1 :
		addr_t'((64'd1 << ADDR_BITS) - 64'd1);

	// Saturated configuration, every field in its legal range
	typedef struct packed {
		eb_t  eb;
		bs_t  bs;
		logic mode;
		nb_t  nb;
		ch_t  ch;
		dim_t hh;
		dim_t ww;
	} cfg_t;

	// Walk position
	typedef struct packed {
		n_t   batch_pos;
		c_t   chan_pos;
		blk_t row_block;
		ph_t  row_phase;
		blk_t col_block;
		ph_t  col_phase;
	} pos_t;

	// Queue entry: one element of the walk
	typedef struct packed {
		pos_t pos;
		logic last;
	} rec_t;

endpackage

>>> hw/rtl/d2s_fifo.sv
`include "depth_to_space_address_generator_core_defines.svh"

module d2s_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  d2s_pkg::rec_t   push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output d2s_pkg::rec_t   pop_data
);

	d2s_pkg::rec_t  mem_q [d2s_pkg::Q_DEPTH];
	d2s_pkg::qptr_t wr_ptr_q;
	d2s_pkg::qptr_t rd_ptr_q;
	d2s_pkg::qcnt_t cnt_q;
	logic           push_fire;
	logic           pop_fire;

	assign push_ready = (cnt_q != d2s_pkg::qcnt_t'(d2s_pkg::Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Pointer advance with wrap at the queue depth
	function automatic d2s_pkg::qptr_t ptr_inc(input d2s_pkg::qptr_t p);
		if (p == d2s_pkg::qptr_t'(d2s_pkg::Q_DEPTH - 1)) begin
			ptr_inc = '0;
		end else begin
			ptr_inc = p + d2s_pkg::qptr_t'(1);
		end
	endfunction

	// Storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop_fire) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + d2s_pkg::qcnt_t'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - d2s_pkg::qcnt_t'(1);
			end
		end
	end

	`D2S_CHECK(a_cnt_bound, cnt_q <= d2s_pkg::qcnt_t'(d2s_pkg::Q_DEPTH))
	`D2S_IMPLY(a_empty_ptrs, cnt_q == '0, wr_ptr_q == rd_ptr_q)
	`D2S_NEXT(a_cnt_up, push_fire && !pop_fire, cnt_q == $past(cnt_q) + d2s_pkg::qcnt_t'(1))

endmodule

>>> hw/rtl/d2s_front.sv
module d2s_front (
	input  logic            clk,
	input  logic            arst_n,
	input  d2s_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            restart,
	output logic            push_valid,
	input  logic            push_ready,
	output d2s_pkg::rec_t   push_data
);

	d2s_pkg::pos_t pos_q;
	d2s_pkg::pos_t cur;
	d2s_pkg::pos_t nxt;
	logic          wrap_bw, wrap_w, wrap_bh, wrap_h, wrap_c, wrap_n;
	logic          cy_w, cy_bh, cy_h, cy_c, cy_n;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// Current position, end-of-axis flags and next position
	always_comb begin
		cur = restart ? '0 : pos_q;

		wrap_bw = int'(cur.col_phase) + 1 >= int'(cfg.bs);
		wrap_w  = int'(cur.col_block) + 1 >= int'(cfg.ww);
		wrap_bh = int'(cur.row_phase) + 1 >= int'(cfg.bs);
		wrap_h  = int'(cur.row_block) + 1 >= int'(cfg.hh);
		wrap_c  = int'(cur.chan_pos)  + 1 >= int'(cfg.ch);
		wrap_n  = int'(cur.batch_pos) + 1 >= int'(cfg.nb);

		// carry into each axis, innermost first
		cy_w  = wrap_bw;
		cy_bh = cy_w && wrap_w;
		cy_h  = cy_bh && wrap_bh;
		cy_c  = cy_h && wrap_h;
		cy_n  = cy_c && wrap_c;

		nxt = cur;
		nxt.col_phase = wrap_bw ? '0 : cur.col_phase + d2s_pkg::ph_t'(1);
		if (cy_w) begin
			nxt.col_block = wrap_w ? '0 : cur.col_block + d2s_pkg::blk_t'(1);
		end
		if (cy_bh) begin
			nxt.row_phase = wrap_bh ? '0 : cur.row_phase + d2s_pkg::ph_t'(1);
		end
		if (cy_h) begin
			nxt.row_block = wrap_h ? '0 : cur.row_block + d2s_pkg::blk_t'(1);
		end
		if (cy_c) begin
			nxt.chan_pos = wrap_c ? '0 : cur.chan_pos + d2s_pkg::c_t'(1);
		end
		if (cy_n) begin
			nxt.batch_pos = wrap_n ? '0 : cur.batch_pos + d2s_pkg::n_t'(1);
		end

		push_data.pos  = cur;
		push_data.last = cy_n && wrap_n;
	end

	// Walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_valid && push_ready) begin
			pos_q <= nxt;
		end
	end

endmodule

>>> hw/rtl/d2s_back.sv
`include "depth_to_space_address_generator_core_defines.svh"

module d2s_back (
	input  logic            clk,
	input  logic            arst_n,
	input  d2s_pkg::cfg_t   cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  d2s_pkg::rec_t   pop_data,
	output logic            out_valid,
	input  logic            out_ready,
	output d2s_pkg::addr_t  src_addr,
	output d2s_pkg::addr_t  dst_addr,
	output logic            last,
	output logic            overflow
);

	logic en;

	// stage 1
	logic             v_s1;
	d2s_pkg::n_t      n_s1;
	d2s_pkg::c_t      c_s1;
	d2s_pkg::pidx_t   pidx_s1;
	d2s_pkg::bs2_t    bs2_s1;
	d2s_pkg::row_t    hrow_s1, wcol_s1, hout_s1, wout_s1;
	d2s_pkg::nch_t    nch_s1;
	d2s_pkg::pin_t    pin_s1;
	d2s_pkg::roff_t   roff_s1;
	logic             last_s1;
	// stage 2
	logic             v_s2;
	d2s_pkg::n_t      n_s2;
	d2s_pkg::cin_t    cin_s2;
	d2s_pkg::ccnt_t   ccnt_s2;
	d2s_pkg::pin_t    pin_s2;
	d2s_pkg::roff_t   roff_s2;
	d2s_pkg::nch_t    nch_s2;
	d2s_pkg::pout_t   pout_s2;
	d2s_pkg::drow_t   drow_s2;
	logic             last_s2;
	// stage 3
	logic             v_s3;
	d2s_pkg::ncin_t   ncin_s3;
	d2s_pkg::pin_t    pin_s3;
	d2s_pkg::roff_t   roff_s3;
	d2s_pkg::dst_t    dst_s3;
	logic             last_s3;
	// stage 4
	logic             v_s4;
	d2s_pkg::src_t    src_s4;
	d2s_pkg::dste_t   dste_s4;
	logic             last_s4;
	// stage 5, output register
	logic             v_s5;
	d2s_pkg::addr_t   src_s5, dst_s5;
	logic             last_s5, ovf_s5;

	// combinational stage results
	d2s_pkg::cin_t    mul_a, mul_b, mul_add;
	d2s_pkg::srce_t   srce;

	// Whole pipeline moves unless the output holds an untaken transaction
	assign en        = !v_s5 || out_ready;
	assign pop_ready = en;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: position products and shape products
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= pop_data.pos.batch_pos;
			c_s1    <= pop_data.pos.chan_pos;
			pidx_s1 <= d2s_pkg::pidx_t'(pop_data.pos.row_phase) * d2s_pkg::pidx_t'(cfg.bs)
				+ d2s_pkg::pidx_t'(pop_data.pos.col_phase);
			bs2_s1  <= d2s_pkg::bs2_t'(cfg.bs) * d2s_pkg::bs2_t'(cfg.bs);
			hrow_s1 <= d2s_pkg::row_t'(pop_data.pos.row_block) * d2s_pkg::row_t'(cfg.bs)
				+ d2s_pkg::row_t'(pop_data.pos.row_phase);
			wcol_s1 <= d2s_pkg::row_t'(pop_data.pos.col_block) * d2s_pkg::row_t'(cfg.bs)
				+ d2s_pkg::row_t'(pop_data.pos.col_phase);
			hout_s1 <= d2s_pkg::row_t'(cfg.hh) * d2s_pkg::row_t'(cfg.bs);
			wout_s1 <= d2s_pkg::row_t'(cfg.ww) * d2s_pkg::row_t'(cfg.bs);
			nch_s1  <= d2s_pkg::nch_t'(pop_data.pos.batch_pos) * d2s_pkg::nch_t'(cfg.ch)
				+ d2s_pkg::nch_t'(pop_data.pos.chan_pos);
			pin_s1  <= d2s_pkg::pin_t'(cfg.hh) * d2s_pkg::pin_t'(cfg.ww);
			roff_s1 <= d2s_pkg::roff_t'(pop_data.pos.row_block) * d2s_pkg::roff_t'(cfg.ww)
				+ d2s_pkg::roff_t'(pop_data.pos.col_block);
			last_s1 <= pop_data.last;
		end
	end

	// Input channel operands by channel order
	always_comb begin
		if (cfg.mode == d2s_pkg::MODE_CRD) begin
			mul_a   = d2s_pkg::cin_t'(c_s1);
			mul_b   = d2s_pkg::cin_t'(bs2_s1);
			mul_add = d2s_pkg::cin_t'(pidx_s1);
		end else begin
			mul_a   = d2s_pkg::cin_t'(pidx_s1);
			mul_b   = d2s_pkg::cin_t'(cfg.ch);
			mul_add = d2s_pkg::cin_t'(c_s1);
		end
	end

	// Stage 2: input channel, channel count, output plane, output row offset
	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= n_s1;
			cin_s2  <= mul_a * mul_b + mul_add;
			ccnt_s2 <= d2s_pkg::ccnt_t'(cfg.ch) * d2s_pkg::ccnt_t'(bs2_s1);
			pin_s2  <= pin_s1;
			roff_s2 <= roff_s1;
			nch_s2  <= nch_s1;
			pout_s2 <= d2s_pkg::pout_t'(hout_s1) * d2s_pkg::pout_t'(wout_s1);
			drow_s2 <= d2s_pkg::drow_t'(hrow_s1) * d2s_pkg::drow_t'(wout_s1)
				+ d2s_pkg::drow_t'(wcol_s1);
			last_s2 <= last_s1;
		end
	end

	// Stage 3: source plane index, destination element offset
	always_ff @(posedge clk) begin
		if (en) begin
			ncin_s3 <= d2s_pkg::ncin_t'(n_s2) * d2s_pkg::ncin_t'(ccnt_s2)
				+ d2s_pkg::ncin_t'(cin_s2);
			pin_s3  <= pin_s2;
			roff_s3 <= roff_s2;
			dst_s3  <= d2s_pkg::dst_t'(nch_s2) * d2s_pkg::dst_t'(pout_s2)
				+ d2s_pkg::dst_t'(drow_s2);
			last_s3 <= last_s2;
		end
	end

	// Stage 4: source element offset, destination byte address
	always_ff @(posedge clk) begin
		if (en) begin
			src_s4  <= d2s_pkg::src_t'(ncin_s3) * d2s_pkg::src_t'(pin_s3)
				+ d2s_pkg::src_t'(roff_s3);
			dste_s4 <= d2s_pkg::dste_t'(dst_s3) * d2s_pkg::dste_t'(cfg.eb);
			last_s4 <= last_s3;
		end
	end

	assign srce = d2s_pkg::srce_t'(src_s4) * d2s_pkg::srce_t'(cfg.eb);

	// Stage 5: source byte address, range check, output register
	always_ff @(posedge clk) begin
		if (en) begin
			src_s5  <= srce[d2s_pkg::FIELD_W-1:0] & d2s_pkg::ADDR_MASK;
			dst_s5  <= dste_s4[d2s_pkg::FIELD_W-1:0] & d2s_pkg::ADDR_MASK;
			ovf_s5  <= ((srce >> d2s_pkg::ADDR_BITS) != '0) ||
				((dste_s4 >> d2s_pkg::ADDR_BITS) != '0);
			last_s5 <= last_s4;
		end
	end

	assign out_valid = v_s5;
	assign src_addr  = src_s5;
	assign dst_addr  = dst_s5;
	assign last      = last_s5;
	assign overflow  = ovf_s5;

	`D2S_NEXT(a_pop_to_s1, pop_valid && en, v_s1)
	`D2S_NEXT(a_s4_to_out, v_s4 && en, v_s5)
	`D2S_NEXT(a_stall_freeze, !en, $stable(v_s1) && $stable(v_s2) && $stable(v_s4))

endmodule

>>> hw/rtl/depth_to_space_address_generator_core.sv
// Depth-to-space address generator (DCR or CRD channel order). Each accepted
// tick transaction yields one source/destination byte address pair, walking the
// output tensor [N, C, H*B, W*B] in row-major order; the final pair of the
// tensor carries last, and restart=1 resets the walk before the pair is made.
// overflow flags a pair whose true address needs more than ADDR_BITS bits.
// Throughput is one pair per clock while the output is not held; an accepted
// tick passes through the front-to-back queue and then the back address
// multiplier stages to the output register. A held output freezes the back
// pipeline; once the four-entry queue is full, in_ready drops. Registers are
// written through the cfg channel (always ready) and must only be written while
// no tick is in flight.
module depth_to_space_address_generator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  d2s_pkg::cfg_idx_t   cfg_index,
	input  d2s_pkg::cfg_data_t  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_ready,
	output d2s_pkg::addr_t      src_addr,
	output d2s_pkg::addr_t      dst_addr,
	output logic                last,
	output logic                overflow
);

	d2s_pkg::eb_t   element_bytes_q;
	d2s_pkg::bs_t   block_size_q;
	logic           order_mode_q;
	d2s_pkg::nb_t   batch_count_q;
	d2s_pkg::ch_t   out_channels_q;
	d2s_pkg::dim_t  in_height_q;
	d2s_pkg::dim_t  in_width_q;
	d2s_pkg::cfg_t  cfg;
	logic           push_valid, push_ready;
	d2s_pkg::rec_t  push_data;
	logic           pop_valid, pop_ready;
	d2s_pkg::rec_t  pop_data;

	// Clamp a register value into 1..hi
	function automatic logic [12:0] sat_val(input logic [12:0] v, input int hi);
		if (v == '0) begin
			sat_val = 13'd1;
		end else if (int'(v) > hi) begin
			sat_val = 13'(hi);
		end else begin
			sat_val = v;
		end
	endfunction

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_bytes_q <= d2s_pkg::eb_t'(1);
			block_size_q    <= d2s_pkg::bs_t'(2);
			order_mode_q    <= d2s_pkg::MODE_DCR;
			batch_count_q   <= d2s_pkg::nb_t'(1);
			out_channels_q  <= d2s_pkg::ch_t'(1);
			in_height_q     <= d2s_pkg::dim_t'(1);
			in_width_q      <= d2s_pkg::dim_t'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				d2s_pkg::REG_ELEMENT_BYTES: element_bytes_q <= cfg_data[d2s_pkg::EB_W-1:0];
				d2s_pkg::REG_BLOCK_SIZE:    block_size_q    <= cfg_data[d2s_pkg::BS_W-1:0];
				d2s_pkg::REG_ORDER_MODE:    order_mode_q    <= cfg_data[0];
				d2s_pkg::REG_BATCH_COUNT:   batch_count_q   <= cfg_data[d2s_pkg::NB_W-1:0];
				d2s_pkg::REG_OUT_CHANNELS:  out_channels_q  <= cfg_data[d2s_pkg::CH_W-1:0];
				d2s_pkg::REG_IN_HEIGHT:     in_height_q     <= cfg_data[d2s_pkg::DIM_W-1:0];
				d2s_pkg::REG_IN_WIDTH:      in_width_q      <= cfg_data[d2s_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturated view of the registers
	always_comb begin
		cfg.eb   = d2s_pkg::eb_t'(sat_val(13'(element_bytes_q), 8));
		cfg.bs   = d2s_pkg::bs_t'(sat_val(13'(block_size_q), d2s_pkg::MAX_BLOCK));
		cfg.mode = order_mode_q;
		cfg.nb   = d2s_pkg::nb_t'(sat_val(13'(batch_count_q), 256));
		cfg.ch   = d2s_pkg::ch_t'(sat_val(out_channels_q, 4096));
		cfg.hh   = d2s_pkg::dim_t'(sat_val(13'(in_height_q), d2s_pkg::MAX_DIM));
		cfg.ww   = d2s_pkg::dim_t'(sat_val(13'(in_width_q), d2s_pkg::MAX_DIM));
	end

	d2s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	d2s_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	d2s_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.last       (last),
		.overflow   (overflow)
	);

endmodule
